// ===== hdl/dsfr_pkg.sv =====
`timescale 1ns / 1ps
package dsfr_pkg;

   localparam int FRAME_BYTES_DEFAULT = 32;
   localparam int HEADER_BYTES        = 2;
   localparam int CHECK_BYTES         = 2;
   localparam int MAX_WORDS           = 14;

   localparam int BYTE_W       = 8;
   localparam int WORD_INDEX_W = 4;
   localparam int WORD_VALUE_W = 16;
   localparam int SUM_W        = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1
   } csr_index_type;

   // shift controls shared by every storage cell
   typedef struct packed {
      logic load;   // take the byte from the upstream neighbour
      logic drain;  // take the byte two places upstream
   } dsfr_shift_type;

endpackage

// ===== hdl/dust_sensor_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// req     | in        | req_tvalid/tready  | tdata[7:0] rx_byte
// rsp     | out       | rsp_tvalid/tready  | tdata[3:0] word_index, [19:4] word_value;
//         |           |                    | tuser frame_ok; tlast last_of_frame
// csr     | in        | csr_valid/ready    | csr_index register, csr_data value
//
// Every byte but the last of a frame is taken back to back.
// The last byte starts a burst of min((FRAME_BYTES-4)/2, 14) words, one per
// cycle out of the cell chain (one item on a checksum error); req_tready is
// low for the burst. rsp_tready low holds the burst; reset is synchronous and
// clears the control state and sync registers, the stored payload needs none.
module dust_sensor_frame_receiver_core
   import dsfr_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_TDATA_W-1:0]   req_tdata,   // [7:0] rx_byte
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,   // [3:0] word_index, [19:4] word_value
   output logic                     rsp_tuser,   // [0] frame_ok
   output logic                     rsp_tlast,   // last_of_frame
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [BYTE_W-1:0]        csr_data
);

   localparam int PAYLOAD_BYTES = FRAME_BYTES - HEADER_BYTES - CHECK_BYTES;
   localparam int WORDS = (PAYLOAD_BYTES / 2 > MAX_WORDS) ? MAX_WORDS : PAYLOAD_BYTES / 2;
   localparam int STORE_BYTES = 2 * WORDS;
   localparam int CNT_W = $clog2(FRAME_BYTES);

   typedef enum logic [1:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      COLLECT,
      EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [BYTE_W-1:0]         chk_hi_ff, chk_hi_in;
   logic                      err_ff, err_in;
   logic [WORD_INDEX_W-1:0]   word_ff, word_in;
   logic [BYTE_W-1:0]         sync_first_ff, sync_first_in;
   logic [BYTE_W-1:0]         sync_second_ff, sync_second_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WORD_INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [WORD_VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      take;
   logic                      slot_free;
   logic [BYTE_W-1:0]         rx_byte;
   dsfr_shift_type            shift;
   logic [BYTE_W-1:0]         cell_q [STORE_BYTES];

   assign rx_byte    = req_tdata[BYTE_W-1:0];
   assign req_tready = (state_ff != EMIT);
   assign take       = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // payload byte enters the chain while still inside the stored window
   assign shift.load  = take && (state_ff == COLLECT)
                        && (cnt_ff >= CNT_W'(HEADER_BYTES))
                        && (cnt_ff < CNT_W'(HEADER_BYTES + STORE_BYTES));
   assign shift.drain = (state_ff == EMIT) && slot_free && !err_ff;

   generate
      for (genvar i = 0; i < STORE_BYTES; i++) begin : g_cell
         logic [BYTE_W-1:0] near_byte;
         logic [BYTE_W-1:0] far_byte;
         if (i == STORE_BYTES - 1) begin : g_tail
            assign near_byte = rx_byte;
            assign far_byte  = '0;
         end else if (i == STORE_BYTES - 2) begin : g_next
            assign near_byte = cell_q[i+1];
            assign far_byte  = '0;
         end else begin : g_body
            assign near_byte = cell_q[i+1];
            assign far_byte  = cell_q[i+2];
         end
         dsfr_cell u_cell (
            .clock     (clock),
            .shift     (shift),
            .near_byte (near_byte),
            .far_byte  (far_byte),
            .cell_byte (cell_q[i])
         );
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      sum_in         = sum_ff;
      chk_hi_in      = chk_hi_ff;
      err_in         = err_ff;
      word_in        = word_ff;
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_index_in   = rsp_index_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_in  = csr_data;
            CSR_SYNC_SECOND: sync_second_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         HUNT_FIRST: begin
            if (take && rx_byte == sync_first_ff) begin
               state_in = HUNT_SECOND;
            end
         end
         HUNT_SECOND: begin
            if (take) begin
               if (rx_byte == sync_second_ff) begin
                  state_in = COLLECT;
                  cnt_in   = CNT_W'(HEADER_BYTES);
                  sum_in   = SUM_W'(sync_first_ff) + SUM_W'(sync_second_ff);
               end else if (rx_byte != sync_first_ff) begin
                  state_in = HUNT_FIRST;
               end
            end
         end
         COLLECT: begin
            if (take) begin
               priority if (cnt_ff < CNT_W'(FRAME_BYTES - CHECK_BYTES)) begin
                  sum_in = sum_ff + SUM_W'(rx_byte);
                  cnt_in = cnt_ff + CNT_W'(1);
               end else if (cnt_ff == CNT_W'(FRAME_BYTES - CHECK_BYTES)) begin
                  chk_hi_in = rx_byte;
                  cnt_in    = cnt_ff + CNT_W'(1);
               end else begin
                  state_in = EMIT;
                  err_in   = ({chk_hi_ff, rx_byte} != sum_ff);
                  word_in  = '0;
               end
            end
         end
         EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_index_in = '0;
                  rsp_value_in = '0;
                  rsp_ok_in    = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = HUNT_FIRST;
               end else begin
                  rsp_index_in = word_ff;
                  rsp_value_in = {cell_q[0], cell_q[1]};
                  rsp_ok_in    = 1'b1;
                  rsp_last_in  = (word_ff == WORD_INDEX_W'(WORDS - 1));
                  word_in      = word_ff + WORD_INDEX_W'(1);
                  if (word_ff == WORD_INDEX_W'(WORDS - 1)) begin
                     state_in = HUNT_FIRST;
                  end
               end
            end
         end
         default: state_in = HUNT_FIRST;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= HUNT_FIRST;
         cnt_ff         <= '0;
         sum_ff         <= '0;
         chk_hi_ff      <= '0;
         err_ff         <= 1'b0;
         word_ff        <= '0;
         sync_first_ff  <= 8'h42;
         sync_second_ff <= 8'h4D;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         sum_ff         <= sum_in;
         chk_hi_ff      <= chk_hi_in;
         err_ff         <= err_in;
         word_ff        <= word_in;
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - WORD_INDEX_W - WORD_VALUE_W){1'b0}},
                        rsp_value_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/dsfr_cell.sv =====
`timescale 1ns / 1ps
module dsfr_cell
   import dsfr_pkg::*;
(
   input  logic                clock,
   input  dsfr_shift_type      shift,
   input  logic [BYTE_W-1:0]   near_byte,
   input  logic [BYTE_W-1:0]   far_byte,
   output logic [BYTE_W-1:0]   cell_byte
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   always_comb begin
      priority if (shift.load) begin
         byte_in = near_byte;
      end else if (shift.drain) begin
         byte_in = far_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== bench/dust_frame_word_checker.sv =====
`timescale 1ns / 1ps
module dust_frame_word_checker
   import dsfr_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_data,
   output int                     fail_count,
   output int                     words_pending,
   output int                     words_checked
);

   localparam int PAYLOAD_BYTES = FRAME_BYTES - HEADER_BYTES - CHECK_BYTES;
   localparam int WORDS_PER_FRAME =
      (PAYLOAD_BYTES / 2 > MAX_WORDS) ? MAX_WORDS : PAYLOAD_BYTES / 2;
   localparam int PAD_LSB = WORD_INDEX_W + WORD_VALUE_W;
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h42;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h4D;

   typedef enum logic [1:0] {
      SEEK_FIRST  = 2'd0,
      SEEK_SECOND = 2'd1,
      GATHER      = 2'd2
   } hunt_state_type;

   typedef struct packed {
      logic [WORD_INDEX_W-1:0] index;
      logic [WORD_VALUE_W-1:0] value;
      logic                    ok;
      logic                    last;
   } frame_word_type;

   frame_word_type              expected_words[$];
   frame_word_type              want;
   frame_word_type              got;
   logic [RSP_TDATA_W-1:PAD_LSB] got_pad;
   logic [BYTE_W-1:0]           first_sync;
   logic [BYTE_W-1:0]           second_sync;
   logic [BYTE_W-1:0]           check_high;
   logic [BYTE_W-1:0]           payload [PAYLOAD_BYTES];
   hunt_state_type              hunt;
   int unsigned                 taken;
   logic [SUM_W-1:0]            byte_sum;

   task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
      logic [SUM_W-1:0] received;
      frame_word_type   w;
      int               k;
      if (hunt == SEEK_SECOND && b == second_sync) begin
         hunt     = GATHER;
         taken    = HEADER_BYTES;
         byte_sum = first_sync + second_sync;
      end else if (hunt != GATHER) begin
         // a wrong second byte is itself tried as a first sync byte
         hunt = (b == first_sync) ? SEEK_SECOND : SEEK_FIRST;
      end else if (taken < FRAME_BYTES - CHECK_BYTES) begin
         byte_sum = byte_sum + b;
         payload[taken - HEADER_BYTES] = b;
         taken++;
      end else if (taken == FRAME_BYTES - CHECK_BYTES) begin
         check_high = b;
         taken++;
      end else begin
         hunt     = SEEK_FIRST;
         taken    = 0;
         received = {check_high, b};
         if (received != byte_sum) begin
            w = '{index: '0, value: '0, ok: 1'b0, last: 1'b1};
            expected_words.push_back(w);
         end else begin
            for (k = 0; k < WORDS_PER_FRAME; k++) begin
               w.index = k[WORD_INDEX_W-1:0];
               w.value = {payload[2*k], payload[2*k+1]};
               w.ok    = 1'b1;
               w.last  = (k + 1 == WORDS_PER_FRAME);
               expected_words.push_back(w);
            end
         end
         byte_sum = '0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         fail_count    = 0;
         words_checked = 0;
         first_sync    = SYNC_FIRST_RESET;
         second_sync   = SYNC_SECOND_RESET;
         check_high    = '0;
         hunt          = SEEK_FIRST;
         taken         = 0;
         byte_sum      = '0;
      end else begin
         // results leaving now belong to bytes taken earlier: compare first
         if (rsp_tvalid && rsp_tready) begin
            got.index = rsp_tdata[WORD_INDEX_W-1:0];
            got.value = rsp_tdata[WORD_INDEX_W +: WORD_VALUE_W];
            got.ok    = rsp_tuser;
            got.last  = rsp_tlast;
            got_pad   = rsp_tdata[RSP_TDATA_W-1:PAD_LSB];
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected item: index %0d value %h ok %b last %b",
                        $time, got.index, got.value, got.ok, got.last);
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (got != want || got_pad != '0) begin
                  fail_count++;
                  $display("%0t: expected index %0d value %h ok %b last %b pad 0",
                           $time, want.index, want.value, want.ok, want.last);
                  $display("%0t:   actual index %0d value %h ok %b last %b pad %h",
                           $time, got.index, got.value, got.ok, got.last, got_pad);
               end
            end
         end
         if (req_tvalid && req_tready)
            parse_rx_byte(req_tdata[BYTE_W-1:0]);
         // a register write counts for bytes taken afterwards
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_FIRST: begin
                  first_sync = csr_data;
               end
               CSR_SYNC_SECOND: begin
                  second_sync = csr_data;
               end
               default: begin
               end
            endcase
         end
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== bench/dust_sensor_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps
module dust_sensor_frame_receiver_core_tb;
   import dsfr_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 24;
   localparam int FRAME_LEN     = FRAME_BYTES_DEFAULT;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef enum int {
      FILL_RANDOM  = 0,
      FILL_ONES    = 1,
      FILL_STRIPES = 2
   } payload_fill_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [BYTE_W-1:0]      csr_data   = '0;

   int          fail_count;
   int          words_pending;
   int          words_checked;
   int          cycles         = 0;
   int          bytes_sent     = 0;
   int          frames_sent    = 0;
   int          settings_used  = 1;
   int          stall_left     = 0;
   bit          src_jitter     = 1'b1;
   bit          sink_jitter    = 1'b1;
   bit          req_up         = 1'b0;
   logic [BYTE_W-1:0] cur_first  = 8'h42;
   logic [BYTE_W-1:0] cur_second = 8'h4D;

   always #CLOCK_HALF clock = ~clock;

   dust_sensor_frame_receiver_core #(
      .FRAME_BYTES(FRAME_LEN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   dust_frame_word_checker #(
      .FRAME_BYTES(FRAME_LEN)
   ) word_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .words_pending(words_pending),
      .words_checked(words_checked)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stall bursts while jitter is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (sink_jitter && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic pause_sender();
      if (req_up) begin
         req_tvalid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (src_jitter && $urandom_range(0, 7) == 0) begin
         pause_sender();
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_up = 1'b1;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input payload_fill_type fill, input bit corrupt);
      logic [BYTE_W-1:0] body [FRAME_LEN];
      logic [SUM_W-1:0]  sum;
      int                i;
      body[0] = cur_first;
      body[1] = cur_second;
      sum     = cur_first + cur_second;
      for (i = HEADER_BYTES; i < FRAME_LEN - CHECK_BYTES; i++) begin
         case (fill)
            FILL_ONES:    body[i] = 8'hFF;
            FILL_STRIPES: body[i] = (i % 2 == 0) ? 8'hFF : 8'h00;
            default:      body[i] = BYTE_W'($urandom_range(0, 255));
         endcase
         sum = sum + body[i];
      end
      if (corrupt)
         sum = sum ^ SUM_W'($urandom_range(1, 65535));
      body[FRAME_LEN-2] = sum[15:8];
      body[FRAME_LEN-1] = sum[7:0];
      for (i = 0; i < FRAME_LEN; i++)
         send_byte(body[i]);
      frames_sent++;
   endtask

   task automatic drain_words(input int extra);
      pause_sender();
      while (words_pending != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [BYTE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic apply_sync(input logic [BYTE_W-1:0] first,
                             input logic [BYTE_W-1:0] second);
      write_register(CSR_SYNC_FIRST, first);
      write_register(CSR_SYNC_SECOND, second);
      csr_valid <= 1'b0;
      cur_first  = first;
      cur_second = second;
      settings_used++;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hunt corner cases at the reset sync values
      send_byte(cur_second);
      send_byte(cur_first);
      send_byte(8'h13);
      send_byte(cur_first);
      send_byte(cur_first);
      send_frame(FILL_ONES, 1'b0);
      send_frame(FILL_RANDOM, 1'b1);

      // hold the sender until every word is out
      drain_words(SETTLE_CYCLES);
      src_jitter = 1'b0;
      write_register(CSR_UNMAPPED, BYTE_W'($urandom_range(0, 255)));
      apply_sync(8'h00, 8'hFF);
      send_frame(FILL_STRIPES, 1'b0);

      // last part: no idling on either side
      sink_jitter = 1'b0;
      drain_words(SETTLE_CYCLES);
      apply_sync(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      send_frame(FILL_RANDOM, 1'b0);

      drain_words(SETTLE_CYCLES);
      $display("Sent %0d bytes, %0d full frames, over %0d sync settings;",
               bytes_sent, frames_sent, settings_used);
      $display("checked %0d payload words and error items.", words_checked);
      if (fail_count == 0 && words_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
